### rtl/core/kpi_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package kpi_pkg;

    localparam int MaxKeys  = 16;
    localparam int MinGapUs = 10;
    localparam int KeyAw    = $clog2(MaxKeys);
    localparam int CountW   = 5;
    localparam int SlotW    = 4;
    localparam int TimeW    = 32;
    localparam int ValW     = 32;
    localparam int NumVals  = 6;
    localparam int ValIdxW  = $clog2(NumVals);
    localparam int FracBits = 16;
    localparam int FracW    = FracBits + 1;
    localparam int DivCntW  = $clog2(FracW + 1);
    localparam int InBits   = SlotW + TimeW + NumVals * ValW;
    localparam int STdataW  = ((InBits + 7) / 8) * 8;
    localparam int MTdataW  = NumVals * ValW;

    localparam logic FuncWrite = 1'b0;
    localparam logic FuncQuery = 1'b1;

    typedef logic [NumVals-1:0][ValW-1:0] key_vals_t;

    typedef struct packed {
        key_vals_t        vals;
        logic [TimeW-1:0] stamp;
    } key_t;

    typedef struct packed {
        logic             wr_en;
        logic [KeyAw-1:0] wr_addr;
        logic             rd_en;
        logic [KeyAw-1:0] rd_addr;
    } ram_req_t;

endpackage

`default_nettype wire

### rtl/core/kpi_key_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module kpi_key_ram (
    input  wire logic            aclk,
    input  wire kpi_pkg::ram_req_t req,
    input  wire kpi_pkg::key_t   wr_data,
    output kpi_pkg::key_t        rd_data
);

    kpi_pkg::key_t mem [kpi_pkg::MaxKeys];
    kpi_pkg::key_t rd_data_reg;

    always_ff @(posedge aclk) begin
        if (req.wr_en) begin
            mem[req.wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (req.rd_en) begin
            rd_data_reg <= mem[req.rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

### rtl/core/kpi_frac_div.sv
`timescale 1ns / 1ps
`default_nettype none

module kpi_frac_div (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        start,
    input  wire logic [kpi_pkg::TimeW-1:0]   num,
    input  wire logic [kpi_pkg::TimeW-1:0]   den,
    output logic                             done,
    output logic [kpi_pkg::FracW-1:0]        quo
);

    logic                          busy_reg;
    logic                          done_reg;
    logic [kpi_pkg::DivCntW-1:0]   cnt_reg;
    logic [kpi_pkg::TimeW:0]       rem_reg;
    logic [kpi_pkg::TimeW-1:0]     den_reg;
    logic [kpi_pkg::FracW-1:0]     quo_reg;
    logic                          bit_next;
    logic [kpi_pkg::TimeW:0]       diff_next;

    always_comb begin
        bit_next  = (rem_reg >= {1'b0, den_reg});
        diff_next = bit_next ? (rem_reg - {1'b0, den_reg}) : rem_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                if (den <= kpi_pkg::TimeW'(kpi_pkg::MinGapUs)) begin
                    done_reg <= 1'b1;
                end else begin
                    busy_reg <= 1'b1;
                    cnt_reg  <= kpi_pkg::DivCntW'(kpi_pkg::FracW);
                end
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == kpi_pkg::DivCntW'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= {1'b0, num};
            den_reg <= den;
            quo_reg <= '0;
        end else if (busy_reg) begin
            rem_reg <= {diff_next[kpi_pkg::TimeW-1:0], 1'b0};
            quo_reg <= {quo_reg[kpi_pkg::FracW-2:0], bit_next};
        end
    end

    assign done = done_reg;
    assign quo  = quo_reg;

endmodule

`default_nettype wire

### rtl/core/kpi_lerp.sv
`timescale 1ns / 1ps
`default_nettype none

module kpi_lerp (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       start,
    input  wire kpi_pkg::key_vals_t         v0,
    input  wire kpi_pkg::key_vals_t         v1,
    input  wire logic [kpi_pkg::FracW-1:0]  frac,
    output logic                            done,
    output kpi_pkg::key_vals_t              pose
);

    localparam int ProdW = kpi_pkg::ValW + kpi_pkg::FracBits;

    logic                          busy_reg;
    logic                          phase_reg;
    logic                          done_reg;
    logic [kpi_pkg::ValIdxW-1:0]   k_reg;
    logic [ProdW-1:0]              prod_reg;
    kpi_pkg::key_vals_t            pose_reg;
    logic signed [kpi_pkg::ValW:0] diff;
    logic signed [kpi_pkg::ValW+kpi_pkg::FracW:0] prod_full;

    always_comb begin
        diff = $signed({v1[k_reg][kpi_pkg::ValW-1], v1[k_reg]})
             - $signed({v0[k_reg][kpi_pkg::ValW-1], v0[k_reg]});
        prod_full = diff * $signed({1'b0, frac});
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg  <= 1'b0;
            phase_reg <= 1'b0;
            done_reg  <= 1'b0;
            k_reg     <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg  <= 1'b1;
                phase_reg <= 1'b0;
                k_reg     <= '0;
            end else if (busy_reg) begin
                phase_reg <= ~phase_reg;
                if (phase_reg) begin
                    if (k_reg == kpi_pkg::ValIdxW'(kpi_pkg::NumVals - 1)) begin
                        busy_reg <= 1'b0;
                        done_reg <= 1'b1;
                    end else begin
                        k_reg <= k_reg + 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (busy_reg && !phase_reg) begin
            prod_reg <= prod_full[ProdW-1:0];
        end
        if (busy_reg && phase_reg) begin
            pose_reg[k_reg] <= v0[k_reg] + prod_reg[ProdW-1:kpi_pkg::FracBits];
        end
    end

    assign done = done_reg;
    assign pose = pose_reg;

endmodule

`default_nettype wire

### rtl/core/keyframe_pose_interpolator.sv
`timescale 1ns / 1ps
`default_nettype none

// Keyframe pose interpolator. A write beat (tuser low) stores one keyframe in the table; a query
// beat (tuser high) returns one pose. The table sits in one synchronous RAM with a single read
// port, so a query reads one keyframe per cycle: an empty table answers with a zero pose without
// a read, a time outside the table span after a read of the first keyframe or of the first and
// the last, and a time inside it scans up to n-1 segments for n keyframes, then runs a
// shift-subtract divide for the fraction and a multiply-add pass over the six values through
// one multiplier. One query is in work at a time; the input takes a new beat as soon as the
// previous query has moved its pose into the output register, even while that pose waits.

module keyframe_pose_interpolator (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    // slot, stamp_us, in_x, in_y, in_z, in_yaw, in_pitch, in_roll, zero fill
    input  wire logic [kpi_pkg::STdataW-1:0]   s_tdata,
    // func
    input  wire logic                          s_tuser,
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    // out_x, out_y, out_z, out_yaw, out_pitch, out_roll
    output logic [kpi_pkg::MTdataW-1:0]        m_tdata,
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [kpi_pkg::CountW-1:0]    cfg_data
);

    typedef enum logic [6:0] {
        ST_IDLE = 7'b0000001,
        ST_CHK0 = 7'b0000010,
        ST_CHKL = 7'b0000100,
        ST_SCAN = 7'b0001000,
        ST_DIV  = 7'b0010000,
        ST_LERP = 7'b0100000,
        ST_DONE = 7'b1000000
    } state_t;

    state_t                          state_reg, state_next;
    logic [kpi_pkg::CountW-1:0]      count_reg;
    logic [kpi_pkg::KeyAw:0]         n_reg, n_next;
    logic [kpi_pkg::KeyAw-1:0]       idx_reg, idx_next;
    logic [kpi_pkg::KeyAw-1:0]       last_idx;
    logic [kpi_pkg::TimeW-1:0]       q_reg, q_next;
    kpi_pkg::key_t                   prev_reg, prev_next;
    kpi_pkg::key_t                   cur_reg, cur_next;
    kpi_pkg::key_vals_t              pose_reg, pose_next;
    kpi_pkg::key_vals_t              out_reg;
    logic                            m_tvalid_reg;

    logic                            s_accept;
    logic                            out_free;
    logic [kpi_pkg::SlotW-1:0]       in_slot;
    logic [kpi_pkg::TimeW-1:0]       in_stamp;
    kpi_pkg::key_t                   wr_key;
    kpi_pkg::ram_req_t               ram_req;
    kpi_pkg::key_t                   rd_key;
    logic                            bracket;
    logic                            div_start, div_done;
    logic [kpi_pkg::TimeW-1:0]       div_num, div_den;
    logic [kpi_pkg::FracW-1:0]       frac;
    logic                            lerp_start, lerp_done;
    kpi_pkg::key_vals_t              lerp_pose;

    assign in_slot   = s_tdata[kpi_pkg::SlotW-1:0];
    assign in_stamp  = s_tdata[kpi_pkg::SlotW +: kpi_pkg::TimeW];
    assign wr_key.stamp = in_stamp;
    assign wr_key.vals  = s_tdata[kpi_pkg::SlotW + kpi_pkg::TimeW +: kpi_pkg::MTdataW];

    assign s_tready  = (state_reg == ST_IDLE);
    assign s_accept  = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign out_free  = !m_tvalid_reg || m_tready;
    assign last_idx  = kpi_pkg::KeyAw'(n_reg - 1'b1);
    assign bracket   = (q_reg >= prev_reg.stamp) && (q_reg <= rd_key.stamp);

    kpi_key_ram u_ram (
        .aclk    (aclk),
        .req     (ram_req),
        .wr_data (wr_key),
        .rd_data (rd_key)
    );

    kpi_frac_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (div_num),
        .den     (div_den),
        .done    (div_done),
        .quo     (frac)
    );

    kpi_lerp u_lerp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (lerp_start),
        .v0      (prev_reg.vals),
        .v1      (cur_reg.vals),
        .frac    (frac),
        .done    (lerp_done),
        .pose    (lerp_pose)
    );

    always_comb begin
        state_next = state_reg;
        n_next     = n_reg;
        idx_next   = idx_reg;
        q_next     = q_reg;
        prev_next  = prev_reg;
        cur_next   = cur_reg;
        pose_next  = pose_reg;
        ram_req    = '0;
        div_start  = 1'b0;
        div_num    = q_reg - prev_reg.stamp;
        div_den    = rd_key.stamp - prev_reg.stamp;
        lerp_start = 1'b0;
        ram_req.wr_addr = kpi_pkg::KeyAw'(in_slot);

        case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    if (s_tuser == kpi_pkg::FuncWrite) begin
                        ram_req.wr_en = (32'(in_slot) < kpi_pkg::MaxKeys);
                    end else begin
                        q_next = in_stamp;
                        if (32'(count_reg) > kpi_pkg::MaxKeys) begin
                            n_next = (kpi_pkg::KeyAw + 1)'(kpi_pkg::MaxKeys);
                        end else begin
                            n_next = (kpi_pkg::KeyAw + 1)'(count_reg);
                        end
                        if (count_reg == '0) begin
                            pose_next  = '0;
                            state_next = ST_DONE;
                        end else begin
                            ram_req.rd_en   = 1'b1;
                            ram_req.rd_addr = '0;
                            state_next      = ST_CHK0;
                        end
                    end
                end
            end
            ST_CHK0: begin
                prev_next = rd_key;
                if (n_reg == (kpi_pkg::KeyAw + 1)'(1) || q_reg <= rd_key.stamp) begin
                    pose_next  = rd_key.vals;
                    state_next = ST_DONE;
                end else begin
                    ram_req.rd_en   = 1'b1;
                    ram_req.rd_addr = last_idx;
                    state_next      = ST_CHKL;
                end
            end
            ST_CHKL: begin
                if (q_reg >= rd_key.stamp) begin
                    pose_next  = rd_key.vals;
                    state_next = ST_DONE;
                end else begin
                    ram_req.rd_en   = 1'b1;
                    ram_req.rd_addr = kpi_pkg::KeyAw'(1);
                    idx_next        = kpi_pkg::KeyAw'(1);
                    state_next      = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (bracket) begin
                    cur_next   = rd_key;
                    div_start  = 1'b1;
                    state_next = ST_DIV;
                end else if (idx_reg == last_idx) begin
                    pose_next  = rd_key.vals;
                    state_next = ST_DONE;
                end else begin
                    prev_next       = rd_key;
                    idx_next        = idx_reg + 1'b1;
                    ram_req.rd_en   = 1'b1;
                    ram_req.rd_addr = idx_reg + 1'b1;
                end
            end
            ST_DIV: begin
                if (div_done) begin
                    lerp_start = 1'b1;
                    state_next = ST_LERP;
                end
            end
            ST_LERP: begin
                if (lerp_done) begin
                    pose_next  = lerp_pose;
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            count_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready) begin
                count_reg <= cfg_data;
            end
            if (state_reg == ST_DONE && out_free) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        n_reg    <= n_next;
        idx_reg  <= idx_next;
        q_reg    <= q_next;
        prev_reg <= prev_next;
        cur_reg  <= cur_next;
        pose_reg <= pose_next;
        if (state_reg == ST_DONE && out_free) begin
            out_reg <= pose_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = out_reg;

    a_div_done_in_div: assert property (@(posedge aclk) disable iff (!aresetn)
        div_done |-> state_reg == ST_DIV)
        else $error("divider finished outside the divide step");

    a_lerp_done_in_lerp: assert property (@(posedge aclk) disable iff (!aresetn)
        lerp_done |-> state_reg == ST_LERP)
        else $error("interpolation finished outside the interpolate step");

    a_scan_idx_range: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_SCAN |-> idx_reg != '0 && (kpi_pkg::KeyAw + 1)'(idx_reg) < n_reg)
        else $error("scan index outside the valid keyframes");

    a_done_loads_output: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_DONE && out_free |=> m_tvalid && state_reg == ST_IDLE)
        else $error("finished pose not moved to the output register");

endmodule

`default_nettype wire

### tb/sv/keyframe_pose_interpolator_tb.sv
`timescale 1ns / 1ps

module keyframe_pose_interpolator_tb;
    import kpi_pkg::*;

    class pose_scoreboard;
        logic [CountW-1:0] key_count;
        logic [TimeW-1:0]  key_time [MaxKeys];
        key_vals_t         key_vals [MaxKeys];
        key_vals_t         pose_q [$];
        int                errors;

        function new();
            key_count = '0;
            errors    = 0;
        endfunction

        function key_vals_t entry_pose(int e);
            return key_vals[e];
        endfunction

        function key_vals_t interpolate(logic [TimeW-1:0] q);
            int          n;
            logic [31:0] dt;
            bit [63:0]   f;
            longint      v0;
            longint      v1;
            longint      r;
            key_vals_t   pose;
            n = (key_count > MaxKeys) ? MaxKeys : int'(key_count);
            if (n == 0) begin
                return '0;
            end
            if (n == 1 || q <= key_time[0]) begin
                return entry_pose(0);
            end
            if (q >= key_time[n-1]) begin
                return entry_pose(n - 1);
            end
            for (int i = 0; i + 1 < n; i++) begin
                if (q >= key_time[i] && q <= key_time[i+1]) begin
                    dt = key_time[i+1] - key_time[i];
                    f  = 0;
                    if (dt > MinGapUs) begin
                        f = (64'(q - key_time[i]) << 16) / 64'(dt);
                    end
                    for (int k = 0; k < NumVals; k++) begin
                        v0 = longint'(signed'(key_vals[i][k]));
                        v1 = longint'(signed'(key_vals[i+1][k]));
                        r  = v0 + (((v1 - v0) * longint'(f)) >>> 16);
                        pose[k] = 32'(r);
                    end
                    return pose;
                end
            end
            return entry_pose(n - 1);
        endfunction

        function void note_beat(logic func, logic [STdataW-1:0] data);
            logic [SlotW-1:0] slot;
            logic [TimeW-1:0] stamp;
            slot  = data[SlotW-1:0];
            stamp = data[SlotW +: TimeW];
            if (func == FuncWrite) begin
                if (slot < MaxKeys) begin
                    key_time[slot] = stamp;
                    key_vals[slot] = data[SlotW+TimeW +: NumVals*ValW];
                end
            end else begin
                pose_q.push_back(interpolate(stamp));
            end
        endfunction

        function void check_pose(key_vals_t got);
            string     field_name [NumVals] = '{"x", "y", "z", "yaw", "pitch", "roll"};
            key_vals_t want;
            if (pose_q.size() == 0) begin
                $display("%0t: pose with no query waiting, got %h", $time, got);
                errors++;
                return;
            end
            want = pose_q.pop_front();
            for (int k = 0; k < NumVals; k++) begin
                if (got[k] !== want[k]) begin
                    $display("%0t: %s expected %h, got %h", $time, field_name[k], want[k],
                             got[k]);
                    errors++;
                end
            end
        endfunction
    endclass

    logic                aclk      = 1'b0;
    logic                aresetn   = 1'b0;
    logic                s_tvalid  = 1'b0;
    logic                s_tready;
    logic [STdataW-1:0]  s_tdata   = '0;
    logic                s_tuser   = 1'b0;
    logic                m_tvalid;
    logic                m_tready  = 1'b0;
    logic [MTdataW-1:0]  m_tdata;
    logic                cfg_valid = 1'b0;
    logic                cfg_ready;
    logic [CountW-1:0]   cfg_data  = '0;

    pose_scoreboard sb;
    int             beats = 0;
    bit             calm  = 1'b0;

    keyframe_pose_interpolator dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    always @(negedge aclk) begin
        m_tready <= calm || ($urandom_range(99) >= 38);
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            sb.check_pose(m_tdata);
        end
    end

    function automatic logic [ValW-1:0] rand_val();
        case ($urandom_range(9))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'($urandom_range(2000)) - 32'd1000;
            default: return $urandom;
        endcase
    endfunction

    function automatic key_vals_t rand_vals();
        key_vals_t v;
        for (int k = 0; k < NumVals; k++) begin
            v[k] = rand_val();
        end
        return v;
    endfunction

    task automatic send_beat(input logic func, input logic [STdataW-1:0] data);
        while (!calm && $urandom_range(99) < 38) begin
            @(negedge aclk);
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tuser  <= func;
        s_tdata  <= data;
        do @(posedge aclk); while (!s_tready);
        sb.note_beat(func, data);
        beats++;
    endtask

    task automatic write_key(input logic [SlotW-1:0] slot, input logic [TimeW-1:0] stamp,
                             input key_vals_t vals);
        send_beat(FuncWrite, STdataW'({vals, stamp, slot}));
    endtask

    task automatic query_pose(input logic [TimeW-1:0] stamp);
        send_beat(FuncQuery, STdataW'({key_vals_t'(rand_vals()), stamp, 4'($urandom)}));
    endtask

    task automatic drain();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (sb.pose_q.size() != 0) begin
            @(posedge aclk);
        end
    endtask

    task automatic set_keyframe_count(input logic [CountW-1:0] value);
        drain();
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        sb.key_count = value;
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // Writes a time-sorted track into slots 0 to n-1, with gaps around the minimum segment.
    task automatic load_track(input int n);
        longint t;
        case ($urandom_range(2))
            0: t = 0;
            1: t = $urandom_range(1000);
            default: t = $urandom;
        endcase
        for (int i = 0; i < n; i++) begin
            write_key(SlotW'(i), 32'(t), rand_vals());
            case ($urandom_range(9))
                0: t += 0;
                1, 2: t += $urandom_range(1, 12);
                3, 4, 5, 6: t += $urandom_range(13, 5000);
                default: t += $urandom_range(1 << 26);
            endcase
            if (t > 64'hFFFF_FFFF) begin
                t = 64'hFFFF_FFFF;
            end
        end
    endtask

    function automatic logic [TimeW-1:0] pick_time(input int n);
        logic [TimeW-1:0] t0;
        logic [TimeW-1:0] tl;
        int               r;
        r = $urandom_range(99);
        if (n == 0) begin
            return $urandom;
        end
        t0 = sb.key_time[0];
        tl = sb.key_time[n-1];
        if (r < 50) begin
            return (tl > t0) ? t0 + $urandom_range(tl - t0) : t0;
        end else if (r < 65) begin
            return sb.key_time[$urandom_range(n - 1)];
        end else if (r < 75) begin
            return sb.key_time[$urandom_range(n - 1)] + ($urandom_range(1) ? 32'd1 : -32'd1);
        end else if (r < 90) begin
            return $urandom;
        end
        return $urandom_range(1) ? 32'h0 : 32'hFFFF_FFFF;
    endfunction

    initial begin
        logic [TimeW-1:0]  t;
        key_vals_t         vals;
        logic [CountW-1:0] cnt;
        int                n;
        int                phase;
        sb = new();
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // An empty table answers with a zero pose.
        query_pose(32'h0);
        query_pose(32'hFFFF_FFFF);

        t = 1000;
        for (int i = 0; i < MaxKeys; i++) begin
            if (i == 3) begin
                t += MinGapUs;
            end else if (i == 4) begin
                t += MinGapUs + 1;
            end else if (i == 15) begin
                t = 32'hFFFF_FFFF;
            end else if (i > 0 && i != 5) begin
                t += 200000 + $urandom_range(50000);
            end
            if (i == 0) begin
                vals = {NumVals{32'h8000_0000}};
            end else if (i == 1) begin
                vals = {NumVals{32'h7FFF_FFFF}};
            end else if (i == 2) begin
                vals = '0;
            end else begin
                vals = rand_vals();
            end
            write_key(SlotW'(i), t, vals);
        end

        set_keyframe_count(5'd16);
        query_pose(32'h0);
        query_pose(sb.key_time[0] + (sb.key_time[1] - sb.key_time[0]) / 2);
        query_pose(sb.key_time[1]);
        query_pose(sb.key_time[2] + 5);
        query_pose(sb.key_time[3] + 5);
        query_pose(sb.key_time[14] + 12345);
        query_pose(32'hFFFF_FFFF);
        set_keyframe_count(5'd1);
        query_pose($urandom);
        set_keyframe_count(5'd31);
        query_pose(sb.key_time[4]);

        phase = 0;
        while (beats < 1000) begin
            calm = (phase >= 6 && phase < 10);
            case ($urandom_range(9))
                0: cnt = 5'd0;
                1: cnt = 5'd1;
                2: cnt = 5'd2;
                3, 4: cnt = 5'd16;
                5: cnt = CountW'($urandom_range(17, 31));
                default: cnt = CountW'($urandom_range(2, 16));
            endcase
            set_keyframe_count(cnt);
            n = (cnt > MaxKeys) ? MaxKeys : int'(cnt);
            if ($urandom_range(4) != 0) begin
                load_track(n);
            end
            repeat ($urandom_range(8, 30)) begin
                if ($urandom_range(99) < 8) begin
                    write_key(SlotW'($urandom_range(MaxKeys - 1)), $urandom, rand_vals());
                end else begin
                    query_pose(pick_time(n));
                end
            end
            phase++;
        end
        calm = 1'b0;

        drain();
        repeat (60) @(posedge aclk);
        if (sb.errors == 0 && sb.pose_q.size() == 0) begin
            $display("keyframe_pose_interpolator_tb: PASS");
        end else begin
            $display("keyframe_pose_interpolator_tb: FAIL");
        end
        $finish;
    end

    initial begin
        #10_000_000;
        $display("keyframe_pose_interpolator_tb: FAIL");
        $finish;
    end

endmodule
